### hdl/tdpt_pkg.sv
// Package for the trial-division prime test: default width, controller
// states and the status word passed back from the serial remainder unit.
// Depends on nothing; tdpt_rem and the top level import it.
`default_nettype none

package tdpt_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } tdpt_state_e;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_sts_t;

endpackage

`default_nettype wire

### hdl/tdpt_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdpt_pkg for the status word type.
`default_nettype none

module tdpt_rem
  import tdpt_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DATA_WIDTH-1:0] dividend_i,
  input  wire logic [DATA_WIDTH-1:0] divisor_i,
  output      rem_sts_t              sts_o
);

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] sh_q, sh_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;

  always_comb begin
    trial  = {rem_q, sh_q[DATA_WIDTH-1]};
    diff   = trial - {1'b0, divisor_i};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      sh_d  = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      sh_d  = {sh_q[DATA_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[DATA_WIDTH-1:0];
      end else begin
        rem_d = trial[DATA_WIDTH-1:0];
      end
      if (cnt_q == CntWidth'(DATA_WIDTH - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.zero = (rem_q == '0);

endmodule

`default_nettype wire

### hdl/trial_division_prime_test.sv
// Top level of the trial-division prime test: controller and trial divisor
// datapath. Depends on tdpt_pkg and instantiates tdpt_rem.
//
// Usage: drive number_i and raise start while busy is low; the word is taken
// at that clock edge. busy stays high until the verdict is given. The result
// word appears on is_prime_o for exactly one cycle, marked by done_o, in the
// last cycle that busy is high; the receiver cannot stall it and must take it
// then. Values below two, negatives included, give a verdict of zero in the
// cycle straight after the word is taken. Otherwise divisors 2, 3, 4 and so on
// are tried while their square does not exceed the number; each divisor gets
// a square test in ST_CHECK and then a pass through the bit-serial remainder
// unit, which handles one dividend bit per cycle. For a 32-bit prime near the
// top of the range about 46340 divisors are tried. One word is in work at a
// time. Reset returns the block to idle with no result pending; nothing is
// kept from one word to the next.
`default_nettype none

module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [DATA_WIDTH-1:0] number_i,
  output      logic                         done_o,
  output      logic                         is_prime_o
);

  tdpt_state_e           state_q, state_d;
  logic [DATA_WIDTH-1:0] n_q, n_d;
  logic [DATA_WIDTH-1:0] d_q, d_d;
  logic [DATA_WIDTH-1:0] sq_q, sq_d;
  logic                  prime_q, prime_d;
  logic                  rem_start;
  logic                  too_small;
  rem_sts_t              rem_sts;

  assign too_small = number_i[DATA_WIDTH-1] || (number_i[DATA_WIDTH-1:1] == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = too_small ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = (sq_q > n_q) ? ST_FINISH : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (rem_sts.done) begin
          state_d = rem_sts.zero ? ST_FINISH : ST_CHECK;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = (state_q != ST_IDLE);
    done_o    = (state_q == ST_FINISH);
    rem_start = (state_q == ST_CHECK) && !(sq_q > n_q);
  end

  always_comb begin
    n_d     = n_q;
    d_d     = d_q;
    sq_d    = sq_q;
    prime_d = prime_q;
    unique case (state_q)
      ST_IDLE: begin
        n_d     = number_i;
        d_d     = DATA_WIDTH'(2);
        sq_d    = DATA_WIDTH'(4);
        prime_d = 1'b0;
      end
      ST_CHECK: begin
        prime_d = (sq_q > n_q);
      end
      ST_DIVIDE: begin
        if (rem_sts.done) begin
          d_d  = d_q + 1'b1;
          sq_d = sq_q + {d_q[DATA_WIDTH-2:0], 1'b1};
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prime_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prime_q <= prime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    d_q  <= d_d;
    sq_q <= sq_d;
  end

  assign is_prime_o = prime_q & done_o;

  tdpt_rem #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .sts_o     (rem_sts)
  );

endmodule

`default_nettype wire

### hdl/tdpt_chk.sv
// Port-level checker for the trial-division prime test, with its binding.
// Depends on the top level's port list only.
`default_nettype none

module tdpt_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire logic is_prime_o
);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_done_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a busy period");

  a_done_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("busy period did not end after the result");

  a_verdict_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !is_prime_o)
    else $error("verdict shown without a strobe");

endmodule

bind trial_division_prime_test tdpt_chk u_tdpt_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .is_prime_o(is_prime_o)
);

`default_nettype wire
